[hdl/ats_pkg.sv]
// Shared types, state codes and transition functions of the assembly token scanner.
package ats_pkg;

    localparam int STATE_W  = 7;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CODE_W   = 6;

    typedef logic [STATE_W-1:0]  state_t;
    typedef logic [BYTE_W-1:0]   byte_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [CODE_W-1:0]   code_t;

    // Status codes
    localparam status_t ST_SEARCH = 2'd0;
    localparam status_t ST_SCAN   = 2'd1;
    localparam status_t ST_TOKEN  = 2'd2;
    localparam status_t ST_ERROR  = 2'd3;

    // Scan-state codes
    localparam state_t SS_ERROR = 7'd33;
    localparam state_t SS_START = 7'd34;
    localparam state_t SS_LAST  = 7'd119;

    // Token kinds that the automaton reaches directly
    localparam state_t TK_EOF     = 7'd1;
    localparam state_t TK_IMM     = 7'd2;
    localparam state_t TK_FLAG    = 7'd3;
    localparam state_t TK_LABEL   = 7'd4;
    localparam state_t TK_COMMENT = 7'd5;
    localparam state_t TK_REG     = 7'd29;
    localparam state_t TK_STRING  = 7'd30;
    localparam state_t TK_COLON   = 7'd31;
    localparam state_t TK_QUEST   = 7'd32;

    // Special characters
    localparam byte_t CH_EOF   = 8'hFF;
    localparam byte_t CH_TAB   = 8'h09;
    localparam byte_t CH_LF    = 8'h0A;
    localparam byte_t CH_CR    = 8'h0D;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_QUOTE = 8'h22;
    localparam byte_t CH_BSL   = 8'h5C;

    // One step of the scanner: next state plus the reported status and code
    typedef struct packed {
        state_t  next_state;
        status_t status;
        code_t   code;
    } ats_step_t;

    function automatic logic is_lbl(byte_t c);
        return (c inside {["a":"z"], ["A":"Z"], ["0":"9"]}) || (c == "_");
    endfunction

    function automatic logic is_hex(byte_t c);
        return c inside {["a":"f"], ["A":"F"], ["0":"9"]};
    endfunction

    // Keyword trie edges; zero where no edge exists
    function automatic state_t kw_next(state_t s, byte_t c);
        state_t e;
        e = '0;
        case ({s, c})
            {7'd35, "H"}:  e = 7'd70;
            {7'd35, "U"}:  e = 7'd71;
            {7'd35, "T"}:  e = 7'd72;
            {7'd35, "W"}:  e = 7'd73;
            {7'd70, "L"}:  e = 7'd74;
            {7'd70, "R"}:  e = 7'd75;
            {7'd71, "B"}:  e = 7'd76;
            {7'd72, "R"}:  e = 7'd77;
            {7'd73, "P"}:  e = 7'd78;
            {7'd36, "N"}:  e = 7'd79;
            {7'd36, "D"}:  e = 7'd80;
            {7'd79, "D"}:  e = 7'd81;
            {7'd80, "D"}:  e = 7'd82;
            {7'd37, "B"}:  e = 7'd83;
            {7'd37, "D"}:  e = 7'd84;
            {7'd83, "I"}:  e = 7'd85;
            {7'd84, "R"}:  e = 7'd86;
            {7'd38, "P"}:  e = 7'd87;
            {7'd38, "L"}:  e = 7'd88;
            {7'd87, "R"}:  e = 7'd89;
            {7'd88, "R"}:  e = 7'd90;
            {7'd39, "R"}:  e = 7'd91;
            {7'd91, "R"}:  e = 7'd92;
            {7'd40, "O"}:  e = 7'd93;
            {7'd93, "R"}:  e = 7'd94;
            {7'd41, "R"}:  e = 7'd95;
            {7'd95, "C"}:  e = 7'd96;
            {7'd42, "O"}:  e = 7'd97;
            {7'd97, "P"}:  e = 7'd98;
            {7'd43, "L"}:  e = 7'd99;
            {7'd99, "T"}:  e = 7'd100;
            {7'd44, "l"}:  e = 7'd101;
            {7'd44, "s"}:  e = 7'd102;
            {7'd44, "d"}:  e = 7'd103;
            {7'd44, "t"}:  e = 7'd104;
            {7'd101, "d"}: e = 7'd105;
            {7'd102, "t"}: e = 7'd106;
            {7'd103, "s"}: e = 7'd107;
            {7'd104, "o"}: e = 7'd108;
            {7'd45, "w"}:  e = 7'd109;
            {7'd45, "a"}:  e = 7'd110;
            {7'd109, "o"}: e = 7'd111;
            {7'd111, "r"}: e = 7'd112;
            {7'd112, "d"}: e = 7'd113;
            {7'd110, "r"}: e = 7'd114;
            {7'd110, "d"}: e = 7'd115;
            {7'd114, "r"}: e = 7'd116;
            {7'd116, "y"}: e = 7'd117;
            {7'd115, "d"}: e = 7'd118;
            {7'd118, "r"}: e = 7'd119;
            default:       e = '0;
        endcase
        return e;
    endfunction

    // Keyword end states and the token each reports; zero elsewhere
    function automatic state_t kw_token(state_t s);
        state_t t;
        case (s)
            7'd74:   t = 7'd6;
            7'd75:   t = 7'd7;
            7'd76:   t = 7'd8;
            7'd77:   t = 7'd9;
            7'd78:   t = 7'd10;
            7'd81:   t = 7'd11;
            7'd82:   t = 7'd12;
            7'd85:   t = 7'd13;
            7'd86:   t = 7'd14;
            7'd89:   t = 7'd15;
            7'd90:   t = 7'd16;
            7'd92:   t = 7'd17;
            7'd94:   t = 7'd18;
            7'd96:   t = 7'd19;
            7'd98:   t = 7'd20;
            7'd100:  t = 7'd21;
            7'd105:  t = 7'd22;
            7'd106:  t = 7'd23;
            7'd107:  t = 7'd24;
            7'd108:  t = 7'd25;
            7'd113:  t = 7'd26;
            7'd117:  t = 7'd27;
            7'd119:  t = 7'd28;
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic state_t start_next(byte_t c);
        state_t n;
        case (c)
            "S":      n = 7'd35;
            "A":      n = 7'd36;
            "L":      n = 7'd37;
            "J":      n = 7'd38;
            "O":      n = 7'd39;
            "X":      n = 7'd40;
            "B":      n = 7'd41;
            "N":      n = 7'd42;
            "H":      n = 7'd43;
            "_":      n = 7'd44;
            ".":      n = 7'd45;
            "$":      n = 7'd46;
            CH_QUOTE: n = 7'd47;
            ":":      n = 7'd48;
            "?":      n = 7'd49;
            "a", "s", "c": n = 7'd50;
            "n":      n = 7'd51;
            "z":      n = 7'd52;
            "p":      n = 7'd53;
            "+", "-": n = 7'd54;
            "0":      n = 7'd55;
            CH_TAB, CH_SPACE, CH_LF, CH_CR: n = SS_START;
            ";":      n = 7'd58;
            CH_EOF:   n = TK_EOF;
            default: begin
                if (c inside {["1":"9"]}) begin
                    n = 7'd56;
                end else if (c inside {["a":"z"], ["A":"Z"]}) begin
                    n = 7'd57;
                end else begin
                    n = SS_ERROR;
                end
            end
        endcase
        return n;
    endfunction

    // Body of a string: escape, closing quote, or stay
    function automatic state_t str_body(byte_t c);
        if (c == CH_BSL) begin
            return 7'd65;
        end else if (c == CH_QUOTE) begin
            return 7'd69;
        end
        return 7'd47;
    endfunction

    function automatic state_t next_state(state_t s, byte_t c);
        state_t e;
        state_t n;
        logic   lbl;
        e   = kw_next(s, c);
        lbl = is_lbl(c);
        case (s)
            SS_START: n = start_next(c);
            7'd54:    n = (c inside {["0":"9"]}) ? 7'd56 : SS_ERROR;
            7'd55: begin
                if (c == "x") begin
                    n = 7'd59;
                end else begin
                    n = (c inside {["0":"9"]}) ? 7'd56 : TK_IMM;
                end
            end
            7'd59:    n = is_hex(c) ? 7'd60 : SS_ERROR;
            7'd46: begin
                if (c inside {["0":"7"]}) begin
                    n = 7'd61;
                end else if (c == "r") begin
                    n = 7'd62;
                end else if (c == "a" || c == "b") begin
                    n = 7'd63;
                end else if (c == "f" || c == "s") begin
                    n = 7'd64;
                end else begin
                    n = SS_ERROR;
                end
            end
            7'd65: begin
                if (c inside {"n", "r", "t", "0", CH_BSL, CH_QUOTE}) begin
                    n = 7'd47;
                end else begin
                    n = (c == "x") ? 7'd66 : SS_ERROR;
                end
            end
            7'd66:    n = is_hex(c) ? 7'd67 : SS_ERROR;
            7'd67:    n = is_hex(c) ? 7'd68 : str_body(c);
            7'd68, 7'd47: n = str_body(c);
            // Flag prefixes: each but state 50 may still grow into a later flag letter
            7'd51: begin
                if (c == "z") begin
                    n = 7'd52;
                end else if (c == "p") begin
                    n = 7'd53;
                end else if (c == "c") begin
                    n = 7'd50;
                end else begin
                    n = lbl ? 7'd57 : TK_FLAG;
                end
            end
            7'd52: begin
                if (c == "p") begin
                    n = 7'd53;
                end else if (c == "c") begin
                    n = 7'd50;
                end else begin
                    n = lbl ? 7'd57 : TK_FLAG;
                end
            end
            7'd53:    n = (c == "c") ? 7'd50 : (lbl ? 7'd57 : TK_FLAG);
            7'd50:    n = lbl ? 7'd57 : TK_FLAG;
            7'd57:    n = lbl ? 7'd57 : TK_LABEL;
            7'd56:    n = (c inside {["0":"9"]}) ? 7'd56 : TK_IMM;
            7'd60:    n = is_hex(c) ? 7'd60 : TK_IMM;
            7'd58:    n = (c == CH_LF) ? TK_COMMENT : 7'd58;
            7'd35, 7'd36, 7'd70, 7'd71, 7'd72, 7'd73, 7'd79, 7'd80: begin
                if (e != '0) begin
                    n = e;
                end else begin
                    n = lbl ? 7'd57 : TK_LABEL;
                end
            end
            7'd37, 7'd38, 7'd39, 7'd40, 7'd41, 7'd42, 7'd43, 7'd44,
            7'd45, 7'd83, 7'd84, 7'd87, 7'd88, 7'd91, 7'd93, 7'd95,
            7'd97, 7'd99, 7'd101, 7'd102, 7'd103, 7'd104, 7'd109,
            7'd110, 7'd111, 7'd112, 7'd114, 7'd115, 7'd116, 7'd118:
                n = (e != '0) ? e : TK_LABEL;
            7'd62:    n = (c inside {["0":"3"]}) ? 7'd61 : SS_ERROR;
            7'd63:    n = (c == "x") ? 7'd61 : SS_ERROR;
            7'd64:    n = (c == "p") ? 7'd61 : SS_ERROR;
            7'd61:    n = lbl ? SS_ERROR : TK_REG;
            7'd69:    n = TK_STRING;
            7'd48:    n = TK_COLON;
            7'd49:    n = TK_QUEST;
            default: begin
                if (kw_token(s) != '0) begin
                    n = lbl ? 7'd57 : kw_token(s);
                end else begin
                    n = SS_ERROR;
                end
            end
        endcase
        return n;
    endfunction

endpackage

[hdl/ats_step.sv]
// One transition of the scanner: next state, status and token code.
module ats_step (
    input  ats_pkg::state_t    cur_state,
    input  ats_pkg::byte_t     peek_byte,
    input  logic               restart,
    output ats_pkg::ats_step_t step
);

    ats_pkg::state_t base_state;
    ats_pkg::state_t nxt;

    assign base_state = restart ? ats_pkg::SS_START : cur_state;
    assign nxt        = ats_pkg::next_state(base_state, peek_byte);

    always_comb begin
        step.next_state = nxt;
        step.code       = '0;
        if (nxt >= ats_pkg::TK_EOF && nxt <= ats_pkg::TK_QUEST) begin
            step.status = ats_pkg::ST_TOKEN;
            step.code   = ats_pkg::CODE_W'(nxt);
        end else if (nxt == ats_pkg::SS_START) begin
            step.status = ats_pkg::ST_SEARCH;
        end else if (nxt > ats_pkg::SS_START && nxt <= ats_pkg::SS_LAST) begin
            step.status = ats_pkg::ST_SCAN;
        end else begin
            step.status = ats_pkg::ST_ERROR;
        end
    end

endmodule

[hdl/assembly_token_scanner_top.sv]
// Top level of the assembly token scanner: stream ports, scan-state register, result register.
//
// Lexer automaton for a small assembly language. Each input transfer carries one lookahead
// byte (0xFF marks end of file) and a restart flag; each produces exactly one result transfer
// with the scan status (searching, scanning, token, error) and a token code 1..32 when a
// token is recognised. A token is reported on the byte after the lexeme, and that byte is
// not consumed: the source must present it again with restart set. Any byte after a token
// or error without restart leads to error. The block takes one byte per clock unless a result
// waits that the sink does not take: the only loop is the single scan-state register feeding
// the transition logic, so a byte may follow in the very next cycle. The registered result is
// valid in the cycle after the input transfer; the result register lets a new byte be taken
// while the previous result is still waiting, as long as the sink takes it in the same cycle.
module assembly_token_scanner_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] peek_byte
    input  logic [0:0] s_tuser,   // [0] restart
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] scan_status, [7:2] token_code
);

    ats_pkg::state_t    state_reg,  state_next;
    logic               mvalid_reg, mvalid_next;
    ats_pkg::status_t   status_reg, status_next;
    ats_pkg::code_t     code_reg,   code_next;
    ats_pkg::ats_step_t step;
    logic               s_xfer;

    // Accept a byte whenever the result slot is empty or drains this cycle
    assign s_tready = !mvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    ats_step u_step (
        .cur_state (state_reg),
        .peek_byte (s_tdata),
        .restart   (s_tuser[0]),
        .step      (step)
    );

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        status_next = status_reg;
        code_next   = code_reg;
        if (s_xfer) begin
            // Advance the automaton and load the result slot
            state_next  = step.next_state;
            mvalid_next = 1'b1;
            status_next = step.status;
            code_next   = step.code;
        end else if (m_tready) begin
            // Drop the result once the sink has taken it
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ats_pkg::SS_START;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
        status_reg <= status_next;
        code_reg   <= code_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {code_reg, status_reg};

    // A token code is present exactly when the status reports a token
    a_code_matches_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((status_reg == ats_pkg::ST_TOKEN) == (code_reg != '0)))
        else $error("token code and status disagree");

    // Searching status only ever reflects the start state
    a_search_is_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status_reg == ats_pkg::ST_SEARCH) |-> (state_reg == ats_pkg::SS_START))
        else $error("searching reported outside start state");

    // From a token or error, a byte without restart leads to error
    a_after_token_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && !s_tuser[0] && state_reg >= ats_pkg::TK_EOF
         && state_reg <= ats_pkg::SS_ERROR) |=> (state_reg == ats_pkg::SS_ERROR))
        else $error("step after token or error did not go to error");

    // Restart with whitespace returns to searching
    a_restart_space: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tuser[0] && s_tdata == ats_pkg::CH_SPACE)
        |=> (state_reg == ats_pkg::SS_START && status_reg == ats_pkg::ST_SEARCH))
        else $error("restart on whitespace did not return to start");

endmodule
